// File: hdl/step_length_bound_reducer_defines.svh
// Assertion macros for the step length bound reducer checker
`ifndef STEP_LENGTH_BOUND_REDUCER_DEFINES_SVH
`define STEP_LENGTH_BOUND_REDUCER_DEFINES_SVH
// assert that an implication holds on every clock edge out of reset
`define SLBR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert that a waiting word keeps valid and payload until it is taken
`define SLBR_HOLD(label, clk, rst_n, vld, rdy, data, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        vld && !rdy |=> vld && $stable(data)) else $error(msg);
`endif

// File: hdl/slbr_pkg.sv
// Package: widths, payload structs and cell control for the reducer
package slbr_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VW = VALUE_WIDTH_DEF;

    typedef enum logic [1:0] {
        REG_LOWER  = 2'd0,
        REG_UPPER  = 2'd1,
        REG_CHANGE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [VW-1:0] old_value;
        logic [VW-1:0] update_value;
        logic          last_element;
    } in_word_t;

    typedef struct packed {
        logic [VW-1:0] theta_lower;
        logic [VW-1:0] theta_upper;
        logic [VW-2:0] theta_change;
    } out_word_t;

    // control held beside the divider chain while an element is worked
    typedef struct packed {
        logic busy;
        logic last;
    } cell_ctl_t;
endpackage

// File: hdl/slbr_div_cell.sv
// Restoring-division cell, three lanes: one quotient bit per cycle while step is high
module slbr_div_cell #(
    parameter int NW = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [2:0][NW-1:0]      rem_in,
    input  logic [2:0][NW-1:0]      num_in,
    input  logic [2:0][NW-1:0]      den_in,
    output logic [2:0][NW-1:0]      rem_out,
    output logic [2:0][NW-1:0]      num_out
);
    import slbr_pkg::*;

    logic [2:0][NW-1:0] rem_reg, rem_next, num_reg, num_next;
    logic [NW:0]        trial;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial       = {rem_in[i], num_in[i][NW-1]};
            num_next[i] = {num_in[i][NW-2:0], 1'b0};
            if (trial >= {1'b0, den_in[i]})
            begin
                rem_next[i]    = NW'(trial - {1'b0, den_in[i]});
                num_next[i][0] = 1'b1;
            end
            else
            begin
                rem_next[i] = trial[NW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            num_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
endmodule

// File: hdl/step_length_bound_reducer.sv
// Top level: step length bound reducer with a chain of division cells
//
// Usage: element words (old_value, update_value, last_element) enter on
// in_valid/in_ready; result words leave on out_valid/out_ready. Per element
// three ratios are formed: lower bound minus old over a negative update,
// upper bound minus old over a positive update, and change factor times
// |old| over |update|; each keeps a running minimum. On the word marked
// last, one result word carries the three minimums and they reset to the
// "no limit" maximum positive value.
// NW = 2*VALUE_WIDTH (64 at the default width). An accepted element steps
// through the row of NW cells, each retiring one quotient bit, then a
// saturate/minimum state folds it into the running minimums. One element
// is worked at a time and in_ready is high only in the idle state.
// Reset clears the minimums to no limit and the bounds to zero.
// A stalled receiver holds the result word; the next element is still taken
// and worked, and a second result waits in its final cycle until the first
// drains, holding off the input meanwhile.
// Write configuration on cfg_valid/cfg_ready only while no element is in flight.
module step_length_bound_reducer #(
    parameter int FRAC_BITS = slbr_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slbr_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output slbr_pkg::out_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import slbr_pkg::*;

    localparam int NW = 2 * VW;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN, S_HOLD} state_t;

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    cell_ctl_t              ctl_reg;
    logic signed [VW-1:0]   lb_reg, ub_reg;
    logic [VW-2:0]          cf_reg;
    logic signed [VW-1:0]   min_lo_reg, min_hi_reg;
    logic [VW-2:0]          min_ch_reg;
    logic [2:0]             use_reg, neg_reg;
    logic [2:0][NW-1:0]     num_reg, den_reg;
    logic [NW:0][2:0][NW-1:0] rem_ch, num_ch;
    out_word_t              out_reg;
    logic                   out_valid_reg;

    logic                   step;
    logic                   emit;
    logic signed [VW:0]     nlo, nhi;
    logic [VW:0]            mlo, mhi;
    logic [VW-1:0]          mold, mupd;
    logic signed [VW-1:0]   ov, uv;
    logic [2:0][VW-1:0]     res;
    logic signed [VW-1:0]   lo_min, hi_min;
    logic [VW-2:0]          ch_min;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign step      = (state_reg == S_DIV);
    // emit a result word once the output register is free
    assign emit      = (state_reg == S_FIN) && ctl_reg.last && (!out_valid_reg || out_ready);

    // row of cells: each advances the quotient of all three lanes by one bit
    assign rem_ch[0] = '0;
    assign num_ch[0] = num_reg;
    for (genvar g = 0; g < NW; g++)
    begin : g_cell
        slbr_div_cell #(.NW(NW)) u_cell (
            .clk(clk), .rst_n(rst_n), .step(step),
            .rem_in(rem_ch[g]), .num_in(num_ch[g]), .den_in(den_reg),
            .rem_out(rem_ch[g+1]), .num_out(num_ch[g+1])
        );
    end

    assign ov   = in_data.old_value;
    assign uv   = in_data.update_value;
    assign nlo  = {lb_reg[VW-1], lb_reg} - {ov[VW-1], ov};
    assign nhi  = {ub_reg[VW-1], ub_reg} - {ov[VW-1], ov};
    assign mlo  = nlo[VW] ? (VW+1)'(0) - nlo : nlo;
    assign mhi  = nhi[VW] ? (VW+1)'(0) - nhi : nhi;
    assign mold = ov[VW-1] ? VW'(0) - ov : ov;
    assign mupd = uv[VW-1] ? VW'(0) - uv : uv;

    // saturate each quotient; an unused lane gives the no limit value
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!use_reg[i])
                res[i] = VMAX;
            else if (neg_reg[i])
                res[i] = (num_ch[NW][i] > NW'(VMAX) + NW'(1)) ? ~VMAX
                         : VW'(NW'(0) - num_ch[NW][i]);
            else
                res[i] = (num_ch[NW][i] > NW'(VMAX)) ? VMAX : num_ch[NW][i][VW-1:0];
        end
    end

    // fold this element into the running minimums
    assign lo_min = ($signed(res[0]) < min_lo_reg) ? res[0] : min_lo_reg;
    assign hi_min = ($signed(res[1]) < min_hi_reg) ? res[1] : min_hi_reg;
    assign ch_min = (res[2][VW-2:0] < min_ch_reg && !res[2][VW-1]) ? res[2][VW-2:0]
                    : min_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ctl_reg       <= '0;
            lb_reg        <= '0;
            ub_reg        <= '0;
            cf_reg        <= '0;
            min_lo_reg    <= VMAX;
            min_hi_reg    <= VMAX;
            min_ch_reg    <= VMAX[VW-2:0];
            use_reg       <= '0;
            neg_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_LOWER:  lb_reg <= cfg_data;
                    REG_UPPER:  ub_reg <= cfg_data;
                    REG_CHANGE: cf_reg <= cfg_data[VW-2:0];
                    default:    ;
                endcase
            end
            // hold the result word until taken; a new one may replace it in the same cycle
            out_valid_reg <= emit || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ctl_reg  <= '{busy: 1'b1, last: in_data.last_element};
                        use_reg  <= {mupd != '0 && mold != '0, !uv[VW-1] && uv != '0,
                                     uv[VW-1]};
                        neg_reg  <= {1'b0, nhi[VW], !nlo[VW] && nlo != '0};
                        num_reg  <= {NW'({cf_reg, 1'b0}) * NW'(mold) >> 1,
                                     NW'(mhi) << FRAC_BITS, NW'(mlo) << FRAC_BITS};
                        den_reg  <= {NW'(mupd), NW'(mupd), NW'(mupd)};
                        cnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NW - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (emit || !ctl_reg.last)
                    begin
                        if (ctl_reg.last)
                        begin
                            out_reg.theta_lower  <= lo_min;
                            out_reg.theta_upper  <= hi_min;
                            out_reg.theta_change <= ch_min;
                            min_lo_reg <= VMAX;
                            min_hi_reg <= VMAX;
                            min_ch_reg <= VMAX[VW-2:0];
                        end
                        else
                        begin
                            min_lo_reg <= lo_min;
                            min_hi_reg <= hi_min;
                            min_ch_reg <= ch_min;
                        end
                        ctl_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// File: hdl/slbr_checker.sv
// Port checker for the step length bound reducer, bound to the top level
`include "step_length_bound_reducer_defines.svh"
module slbr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input slbr_pkg::out_word_t out_data
);
    `SLBR_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_data, "result word dropped")
    `SLBR_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "took two words back to back")
    `SLBR_ASSERT(a_rise, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result without work")
endmodule

bind step_length_bound_reducer slbr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: verif/step_length_bound_reducer_test.sv
`timescale 1ns / 100ps
// Testbench for the step length bound reducer: directed table, then random vectors
module step_length_bound_reducer_test;
    import slbr_pkg::*;

    localparam logic signed [31:0] NO_LIMIT = 32'sh7FFF_FFFF;
    localparam int LIMIT_CYCLES = 1500000;
    localparam out_word_t ALL_FREE = '{theta_lower: 32'h7FFF_FFFF,
                                       theta_upper: 32'h7FFF_FFFF,
                                       theta_change: 31'h7FFF_FFFF};

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #6 clk = ~clk;

    step_length_bound_reducer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the configuration and the running minimums
    logic signed [31:0] lo_bound, hi_bound;
    logic [30:0] gamma;
    logic signed [31:0] run_lo, run_hi;
    logic [30:0] run_chg;

    out_word_t pending_thetas[$];
    int errors = 0;
    int mismatches = 0;
    int cycle = 0;

    // saturate a magnitude quotient with sign to the 32-bit signed range
    function automatic logic signed [31:0] clamp_q(logic [63:0] q, logic neg);
        if (neg)
        begin
            if (q > 64'h8000_0000)
                return 32'sh8000_0000;
            return -$signed(q[31:0]);
        end
        if (q > 64'h7FFF_FFFF)
            return NO_LIMIT;
        return q[31:0];
    endfunction

    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic signed [31:0] q_ratio(logic signed [63:0] num,
                                                   logic signed [63:0] den);
        logic [63:0] q;
        q = (magnitude(num) << 16) / magnitude(den);
        return clamp_q(q, (num < 0) != (den < 0));
    endfunction

    // fold one element into the minimums; push the thetas on the last word
    task automatic fold_element(in_word_t w);
        logic signed [63:0] o, u;
        logic signed [31:0] lo, hi, ch;
        out_word_t r;
        o = $signed(w.old_value);
        u = $signed(w.update_value);
        lo = NO_LIMIT;
        hi = NO_LIMIT;
        ch = NO_LIMIT;
        if (u < 0)
            lo = q_ratio(64'(lo_bound) - o, u);
        if (u > 0)
            hi = q_ratio(64'(hi_bound) - o, u);
        if (u != 0 && o != 0)
            ch = clamp_q((64'(gamma) * magnitude(o)) / magnitude(u), 1'b0);
        if (lo < run_lo)
            run_lo = lo;
        if (hi < run_hi)
            run_hi = hi;
        if ($signed({1'b0, ch[30:0]}) < $signed({1'b0, run_chg}) && ch[31] == 1'b0)
            run_chg = ch[30:0];
        if (w.last_element)
        begin
            r.theta_lower = run_lo;
            r.theta_upper = run_hi;
            r.theta_change = run_chg;
            pending_thetas.push_back(r);
            run_lo = NO_LIMIT;
            run_hi = NO_LIMIT;
            run_chg = NO_LIMIT[30:0];
        end
    endtask

    // compare the newest expectation with a value typed into the table
    task automatic check_typed(out_word_t want);
        out_word_t got;
        got = pending_thetas[$];
        if (got !== want)
        begin
            errors++;
            if (mismatches++ < 10)
                $display("typed row: expected %h, predicted %h", want, got);
        end
    endtask

    // write one register; only called while idle, valid dropped by the caller
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LOWER:  lo_bound = value;
            REG_UPPER:  hi_bound = value;
            REG_CHANGE: gamma = value[30:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(logic [31:0] l, logic [31:0] h, logic [31:0] g);
        write_reg(REG_LOWER, l);
        write_reg(REG_UPPER, h);
        write_reg(REG_CHANGE, g);
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts with random gaps; hold valid and payload until accepted
    int burst_left = 0;
    task automatic send_element(in_word_t w);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        fold_element(w);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // wait out all expected results plus the block's latency
    task automatic drain();
        drop_valid();
        wait (pending_thetas.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    // receiver: its own stall pattern, plus one long hold-off
    logic long_hold = 1'b0;
    always @(posedge clk)
    begin
        if (long_hold)
            out_ready <= 1'b0;
        else
            case (cycle[9:8])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    // checker: compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_thetas.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result word %h", out_data);
            end
            else
            begin
                out_word_t e;
                e = pending_thetas.pop_front();
                if (e !== out_data)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected lo %h hi %h chg %h, got lo %h hi %h chg %h",
                                 e.theta_lower, e.theta_upper, e.theta_change,
                                 out_data.theta_lower, out_data.theta_upper,
                                 out_data.theta_change);
                end
            end
        end
        if (cycle == LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // directed rows: payload, and a typed result where it is plain to see
    typedef struct {
        logic [31:0] old_v;
        logic [31:0] upd_v;
        logic        last;
        logic        known;
        out_word_t   want;
    } row_t;

    row_t directed[] = '{
        // all zero: no limit in every field
        '{32'h0, 32'h0, 1'b1, 1'b1, ALL_FREE},
        // zero update with nonzero old
        '{32'h0001_0000, 32'h0, 1'b1, 1'b1, ALL_FREE},
        // zero old value, positive and negative update
        '{32'h0, 32'h0001_0000, 1'b0, 1'b0, ALL_FREE},
        '{32'h0, 32'hFFFF_0000, 1'b1, 1'b0, ALL_FREE},
        // extremes
        '{32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, ALL_FREE},
        '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ALL_FREE},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, ALL_FREE},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, ALL_FREE},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, ALL_FREE},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, ALL_FREE},
        // old value inside the bounds, update toward a bound: positive ratios
        '{32'h0005_0000, 32'h0001_0000, 1'b0, 1'b0, ALL_FREE},
        '{32'hFFFB_0000, 32'hFFFF_0000, 1'b1, 1'b0, ALL_FREE},
        // vector of several elements
        '{32'h0002_0000, 32'h0000_8000, 1'b0, 1'b0, ALL_FREE},
        '{32'hFFFE_0000, 32'hFFFF_8000, 1'b0, 1'b0, ALL_FREE},
        '{32'h0010_0000, 32'h0003_0000, 1'b1, 1'b0, ALL_FREE}
    };

    in_word_t w;
    int n;
    initial
    begin
        rst_n = 1'b0;
        lo_bound = 0;
        hi_bound = 0;
        gamma = 0;
        run_lo = NO_LIMIT;
        run_hi = NO_LIMIT;
        run_chg = NO_LIMIT[30:0];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first row after reset: everything zero, so no limit anywhere
        w = '{old_value: 0, update_value: 0, last_element: 1'b1};
        send_element(w);
        check_typed(ALL_FREE);
        drop_valid();
        wait (pending_thetas.size() == 0);

        set_config(32'hFFF0_0000, 32'h0010_0000, 32'h0000_8000);
        foreach (directed[i])
        begin
            w.old_value = directed[i].old_v;
            w.update_value = directed[i].upd_v;
            w.last_element = directed[i].last;
            send_element(w);
            if (directed[i].known)
                check_typed(directed[i].want);
        end
        drain();
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        foreach (directed[i])
        begin
            w.old_value = directed[i].old_v;
            w.update_value = directed[i].upd_v;
            w.last_element = directed[i].last;
            send_element(w);
            if (directed[i].known)
                check_typed(directed[i].want);
        end
        drain();

        // long receiver hold-off while the sender keeps offering
        long_hold = 1'b1;
        fork
        begin
            repeat (600) @(posedge clk);
            long_hold = 1'b0;
        end
        join_none

        // random phases, each with its own configuration
        for (int phase = 0; phase < 6; phase++)
        begin
            n = 270;
            for (int k = 0; k < n; k++)
            begin
                w.old_value = ($urandom_range(0, 3) == 0) ? $urandom()
                            : 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
                case ($urandom_range(0, 5))
                    0:       w.update_value = 0;
                    1:       w.update_value = $urandom();
                    default: w.update_value = 32'($signed($urandom_range(1, 32'h0003_FFFF))
                                                  - 32'sh0002_0000);
                endcase
                if ($urandom_range(0, 9) == 0)
                    w.old_value = 0;
                w.last_element = ($urandom_range(0, 7) == 0);
                send_element(w);
            end
            w = '{old_value: $urandom(), update_value: $urandom(), last_element: 1'b1};
            send_element(w);
            drain();
            if (phase == 4)
                set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
            else
                set_config($urandom(), $urandom(), $urandom());
        end

        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
